### design/id_string_format_classifier_macros.svh
// Assertion macros shared by the identifier format classifier modules.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ID_STRING_FORMAT_CLASSIFIER_MACROS_SVH
`define ID_STRING_FORMAT_CLASSIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define IDSCF_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expr must never be true outside reset
`define IDSCF_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define IDSCF_ASSERT(lbl, clk, rstn, prop, msg)
`define IDSCF_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

### design/idscf_pkg.sv
// Types and constants of the identifier string format classifier.
// No dependencies; used by the front end, the back end and the top module.
package idscf_pkg;

	localparam int LEN_W = 9;
	localparam logic [LEN_W-1:0] LEN_CAP = 9'd256;

	// format numbers
	localparam logic [4:0] FMT_DEFAULT   = 5'd1;
	localparam logic [4:0] FMT_SHORT     = 5'd2;
	localparam logic [4:0] FMT_UUID_LOW  = 5'd3;
	localparam logic [4:0] FMT_HEX64     = 5'd4;
	localparam logic [4:0] FMT_CAESE     = 5'd5;
	localparam logic [4:0] FMT_HEX40     = 5'd6;
	localparam logic [4:0] FMT_B64_8     = 5'd7;
	localparam logic [4:0] FMT_B64_12    = 5'd8;
	localparam logic [4:0] FMT_HEX32     = 5'd9;
	localparam logic [4:0] FMT_AID       = 5'd10;
	localparam logic [4:0] FMT_UPHEX32   = 5'd11;
	localparam logic [4:0] FMT_UUID_UP   = 5'd12;
	localparam logic [4:0] FMT_HEX24     = 5'd13;
	localparam logic [4:0] FMT_UINT      = 5'd15;
	localparam logic [4:0] FMT_HEX96     = 5'd16;

	// ASCII codes
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_C  = 8'h43;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_UP_S  = 8'h53;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_D  = 8'h64;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_LO_I  = 8'h69;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
		logic       is_empty;
	} in_item_t;

	typedef struct packed {
		logic [4:0]       format_id;
		logic [LEN_W-1:0] length_capped;
	} out_item_t;

	// per-character class bits passed from the front to the back
	typedef struct packed {
		logic is_dec;
		logic is_zero;
		logic is_low_hex;
		logic is_up_hex;
		logic is_b64;
		logic is_dash;
		logic is_lo_a;
		logic is_lo_i;
		logic is_lo_d;
		logic is_up_a;
		logic is_up_c;
		logic is_up_e;
		logic is_up_s;
		logic is_last;
		logic is_empty;
	} char_class_t;

endpackage

### design/idscf_front.sv
// Front end: classifies one incoming character into class bits.
// Depends on idscf_pkg.
module idscf_front (
	input  idscf_pkg::in_item_t    item,
	output idscf_pkg::char_class_t cls
);
	import idscf_pkg::*;

	logic [7:0] c;
	logic dec, lo_alpha, up_alpha, lo_af, up_af;

	assign c = item.char_code;

	always_comb begin
		dec      = (c >= CH_0) && (c <= CH_9);
		lo_alpha = (c >= CH_LO_A) && (c <= CH_LO_Z);
		up_alpha = (c >= CH_UP_A) && (c <= CH_UP_Z);
		lo_af    = (c >= CH_LO_A) && (c <= CH_LO_F);
		up_af    = (c >= CH_UP_A) && (c <= CH_UP_F);

		cls.is_dec     = dec;
		cls.is_zero    = (c == CH_0);
		cls.is_low_hex = dec || lo_af;
		cls.is_up_hex  = dec || up_af;
		cls.is_b64     = dec || lo_alpha || up_alpha || (c == CH_UNDER) || (c == CH_DASH);
		cls.is_dash    = (c == CH_DASH);
		cls.is_lo_a    = (c == CH_LO_A);
		cls.is_lo_i    = (c == CH_LO_I);
		cls.is_lo_d    = (c == CH_LO_D);
		cls.is_up_a    = (c == CH_UP_A);
		cls.is_up_c    = (c == CH_UP_C);
		cls.is_up_e    = (c == CH_UP_E);
		cls.is_up_s    = (c == CH_UP_S);
		cls.is_last    = item.is_last;
		cls.is_empty   = item.is_empty;
	end

endmodule

### design/idscf_fifo.sv
// Small register-based queue, used between front and back and on the result side.
// Depends on id_string_format_classifier_macros.svh.
`include "id_string_format_classifier_macros.svh"

module idscf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q, count_d;
	logic             push_ok, pop_ok;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];
	assign count_d = count_q + CW'(push_ok) - CW'(pop_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop_ok)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok)
			mem_q[wr_ptr_q] <= wr_data;
	end

	`IDSCF_NEVER(a_count_range, clk, arst_n, count_q > CW'(DEPTH), "fifo count above depth")
	`IDSCF_ASSERT(a_count_step, clk, arst_n, 1'b1 |=> (count_q == $past(count_d)), "count out of step")

endmodule

### design/idscf_back.sv
// Back end: running length count and class flags per string, format pick at end.
// Depends on idscf_pkg and id_string_format_classifier_macros.svh.
`include "id_string_format_classifier_macros.svh"

module idscf_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  idscf_pkg::char_class_t cls,
	input  logic                   cls_empty,
	output logic                   cls_pop,
	input  logic                   res_full,
	output logic                   res_push,
	output idscf_pkg::out_item_t   res
);
	import idscf_pkg::*;

	typedef struct packed {
		logic all_dec;
		logic lead_nz;
		logic all_low_hex;
		logic all_up_hex;
		logic all_b64;
		logic uuid_low;
		logic uuid_up;
		logic aid_ok;
		logic caese_ok;
	} flags_t;

	localparam flags_t FLAGS_START = '1;

	logic [LEN_W-1:0] char_count_q, count_n;
	flags_t           flags_q, flags_n;
	logic [LEN_W-1:0] pos;
	logic             dash_pos, in_uuid;
	logic [4:0]       fmt;

	assign pos      = char_count_q;
	assign cls_pop  = !cls_empty && !res_full;
	assign res_push = cls_pop && cls.is_last;

	// per-character length count and flag update
	always_comb begin
		dash_pos = (pos == 9'd8) || (pos == 9'd13) || (pos == 9'd18) || (pos == 9'd23);
		in_uuid  = (pos < 9'd36);
		flags_n  = flags_q;
		count_n  = char_count_q;
		if (!cls.is_empty) begin
			count_n = char_count_q[LEN_W-1] ? char_count_q : char_count_q + 1'b1;
			flags_n.all_dec     = flags_q.all_dec && cls.is_dec;
			flags_n.lead_nz     = flags_q.lead_nz && !((pos == '0) && cls.is_zero);
			flags_n.all_low_hex = flags_q.all_low_hex && cls.is_low_hex;
			flags_n.all_up_hex  = flags_q.all_up_hex && cls.is_up_hex;
			flags_n.all_b64     = flags_q.all_b64 && cls.is_b64;
			if (in_uuid) begin
				if (dash_pos) begin
					flags_n.uuid_low = flags_q.uuid_low && cls.is_dash;
					flags_n.uuid_up  = flags_q.uuid_up && cls.is_dash;
				end else begin
					flags_n.uuid_low = flags_q.uuid_low && cls.is_low_hex;
					flags_n.uuid_up  = flags_q.uuid_up && cls.is_up_hex;
				end
			end
			unique case (pos)
				9'd0:    flags_n.aid_ok = flags_q.aid_ok && cls.is_lo_a;
				9'd1:    flags_n.aid_ok = flags_q.aid_ok && cls.is_lo_i;
				9'd2:    flags_n.aid_ok = flags_q.aid_ok && cls.is_lo_d;
				default: flags_n.aid_ok = flags_q.aid_ok && cls.is_low_hex;
			endcase
			unique case (pos)
				9'd0:    flags_n.caese_ok = flags_q.caese_ok && cls.is_up_c;
				9'd1:    flags_n.caese_ok = flags_q.caese_ok && cls.is_up_a;
				9'd2:    flags_n.caese_ok = flags_q.caese_ok && cls.is_up_e;
				9'd3:    flags_n.caese_ok = flags_q.caese_ok && cls.is_up_s;
				9'd4:    flags_n.caese_ok = flags_q.caese_ok && cls.is_up_e;
				default: flags_n.caese_ok = flags_q.caese_ok && cls.is_b64;
			endcase
		end
	end

	// first matching test wins
	always_comb begin
		priority if ((count_n >= 9'd1) && (count_n <= 9'd9) && flags_n.lead_nz && flags_n.all_dec)
			fmt = FMT_UINT;
		else if ((count_n == 9'd36) && flags_n.uuid_low)     fmt = FMT_UUID_LOW;
		else if ((count_n == 9'd24) && flags_n.all_low_hex)  fmt = FMT_HEX24;
		else if ((count_n == 9'd32) && flags_n.all_low_hex)  fmt = FMT_HEX32;
		else if ((count_n == 9'd40) && flags_n.all_low_hex)  fmt = FMT_HEX40;
		else if ((count_n == 9'd64) && flags_n.all_low_hex)  fmt = FMT_HEX64;
		else if ((count_n == 9'd32) && flags_n.all_up_hex)   fmt = FMT_UPHEX32;
		else if ((count_n == 9'd96) && flags_n.all_low_hex)  fmt = FMT_HEX96;
		else if ((count_n == 9'd35) && flags_n.aid_ok)       fmt = FMT_AID;
		else if ((count_n == 9'd36) && flags_n.uuid_up)      fmt = FMT_UUID_UP;
		else if ((count_n == 9'd27) && flags_n.caese_ok)     fmt = FMT_CAESE;
		else if ((count_n == 9'd8) && flags_n.all_b64)       fmt = FMT_B64_8;
		else if ((count_n == 9'd12) && flags_n.all_b64)      fmt = FMT_B64_12;
		else if (count_n < LEN_CAP)                          fmt = FMT_SHORT;
		else                                                 fmt = FMT_DEFAULT;
	end

	assign res.format_id     = fmt;
	assign res.length_capped = count_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
			flags_q      <= FLAGS_START;
		end else if (cls_pop) begin
			if (cls.is_last) begin
				char_count_q <= '0;
				flags_q      <= FLAGS_START;
			end else begin
				char_count_q <= count_n;
				flags_q      <= flags_n;
			end
		end
	end

	`IDSCF_NEVER(a_count_cap, clk, arst_n, char_count_q > LEN_CAP, "length count above cap")
	`IDSCF_ASSERT(a_restart, clk, arst_n, res_push |=> (char_count_q == '0 && flags_q == FLAGS_START), "state not restarted after string end")

endmodule

### design/id_string_format_classifier.sv
// Identifier string format classifier. Characters enter one per clock while full
// is low, through a queue-style port (push/full), and leave as one result per
// string (empty/pop). The front end classifies each character and writes it into
// a CLASS_DEPTH-entry queue; the back end takes one entry per clock while the
// result queue is not full, updates the length count and class flags, and on the
// last character writes format and capped length into a RESULT_DEPTH-entry result
// queue. Sustained rate is one character per clock while the result queue is not
// full, set by the back end's flag update. The last character is registered in the
// class queue, and its result in the result queue, before the result can be popped.
// Depends on idscf_pkg, idscf_front, idscf_fifo and idscf_back.
module id_string_format_classifier #(
	parameter int CLASS_DEPTH  = 4,
	parameter int RESULT_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  idscf_pkg::in_item_t  char_item,
	output logic                 empty,
	input  logic                 pop,
	output idscf_pkg::out_item_t result
);
	import idscf_pkg::*;

	char_class_t cls_in, cls_out;
	out_item_t   res_in;
	logic        cls_empty, cls_pop;
	logic        res_full, res_push;

	idscf_front u_front (
		.item (char_item),
		.cls  (cls_in)
	);

	idscf_fifo #(
		.WIDTH ($bits(char_class_t)),
		.DEPTH (CLASS_DEPTH)
	) u_cls_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (cls_in),
		.full    (full),
		.pop     (cls_pop),
		.rd_data (cls_out),
		.empty   (cls_empty)
	);

	idscf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (cls_out),
		.cls_empty (cls_empty),
		.cls_pop   (cls_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	idscf_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (RESULT_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.pop     (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule
